/* hdl/tarsm_pkg.sv */
// shared types, constants and register codes for the tilt and rate safety monitor
`timescale 1ns / 1ps
`default_nettype none

package tarsm_pkg;

  localparam int TILT_W    = 16;
  localparam int SQ_W      = 31;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 7;
  localparam int HGT_W     = 15;
  localparam int RATE_W    = 15;
  localparam int MAG_W     = 17;

  localparam int IN_W      = 80;
  localparam int OUT_W     = 24;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 16;

  localparam int HISTORY_DEPTH = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX  = 7'd100;
  localparam logic [CNT_W-1:0] NEAR_LEVEL = 7'd50;

  localparam logic [TILT_W-1:0] TILT_ONE   = 16'h7FFF;
  localparam logic [SUM_W-1:0]  TILT_ROUND = 32'd8192;
  localparam int                TILT_SHIFT = 14;

  localparam logic                     ENABLE_RST      = 1'b1;
  localparam logic [HGT_W-1:0]         GROUND_HGT_RST  = 15'd300;
  localparam logic signed [TILT_W-1:0] GROUND_TILT_RST = 16'sd25102;
  localparam logic signed [TILT_W-1:0] FLIGHT_TILT_RST = 16'sd21063;
  localparam logic [RATE_W-1:0]        RATE_LIMIT_RST  = 15'd4915;

  typedef enum logic [CFG_AW-1:0] {
    CFG_ENABLE      = 3'd0,
    CFG_GROUND_HGT  = 3'd1,
    CFG_GROUND_TILT = 3'd2,
    CFG_FLIGHT_TILT = 3'd3,
    CFG_RATE_LIMIT  = 3'd4
  } cfg_idx_t;

  // what the front stage hands to the decision stage
  typedef struct packed {
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;
    logic            height_low;
    logic            rate_over;
  } front_t;

endpackage

`default_nettype wire

/* hdl/tarsm_front.sv */
// front stage: squares of the quaternion parts, height and rate compares, registered
`timescale 1ns / 1ps
`default_nettype none

module tarsm_front (
  input  wire                                    clk,
  input  wire                                    load,
  input  wire  [tarsm_pkg::IN_W-1:0]             in_data,
  input  wire  [tarsm_pkg::HGT_W-1:0]            ground_height_mm,
  input  wire  [tarsm_pkg::RATE_W-1:0]           rate_limit,
  output tarsm_pkg::front_t                      front_r
);

  logic signed [tarsm_pkg::TILT_W-1:0]   qx;
  logic signed [tarsm_pkg::TILT_W-1:0]   qy;
  logic signed [tarsm_pkg::TILT_W-1:0]   height;
  logic        [tarsm_pkg::TILT_W-1:0]   wr;
  logic        [tarsm_pkg::TILT_W-1:0]   wp;
  logic signed [2*tarsm_pkg::TILT_W-1:0] px;
  logic signed [2*tarsm_pkg::TILT_W-1:0] py;
  logic        [tarsm_pkg::MAG_W-1:0]    mag_r;
  logic        [tarsm_pkg::MAG_W-1:0]    mag_p;
  logic        [tarsm_pkg::MAG_W-1:0]    lim;
  tarsm_pkg::front_t                     front_nxt;

  assign qx     = in_data[15:0];
  assign qy     = in_data[31:16];
  assign height = in_data[47:32];
  assign wr     = in_data[63:48];
  assign wp     = in_data[79:64];

  assign px = qx * qx;
  assign py = qy * qy;

  // magnitude of the most negative rate is 32768, hence the extra bit
  assign mag_r = wr[15] ? (17'({1'b0, ~wr}) + 17'd1) : {1'b0, wr};
  assign mag_p = wp[15] ? (17'({1'b0, ~wp}) + 17'd1) : {1'b0, wp};
  assign lim   = {2'b00, rate_limit};

  always_comb begin
    front_nxt.sq_x       = px[tarsm_pkg::SQ_W-1:0];
    front_nxt.sq_y       = py[tarsm_pkg::SQ_W-1:0];
    front_nxt.height_low = height < $signed({1'b0, ground_height_mm});
    front_nxt.rate_over  = (mag_r > lim) || (mag_p > lim);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      front_r <= front_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/tarsm_hist_cell.sv */
// one history cell: holds a sample, passes it on, flags whether its next value is below limit
`timescale 1ns / 1ps
`default_nettype none

module tarsm_hist_cell (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     shift,
  input  wire  signed [tarsm_pkg::TILT_W-1:0]     d_in,
  input  wire  signed [tarsm_pkg::TILT_W-1:0]     limit,
  output logic signed [tarsm_pkg::TILT_W-1:0]     val_r,
  output logic                                    below_nxt
);

  // the flag looks at the value the cell holds once the shift is done
  assign below_nxt = d_in < limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (shift) begin
      val_r <= d_in;
    end
  end

endmodule

`default_nettype wire

/* hdl/tilt_and_rate_safety_monitor.sv */
// top level of the tilt and rate safety monitor: handshake, tilt cosine, counter, cell rows
// Usage:
//   in_* carries one sensor request per control tick: quat_x, quat_y, height_mm,
//   rate_roll and rate_pitch. out_* returns one result request per input: the
//   tilt cosine r33 and the trip flags. cfg_* writes the four limit registers and
//   the enable bit; write them only while no request is in flight.
// Path: input accept loads the square stage, then the decision stage updates the
//   ground counter and both history cell rows and registers the result for out_tvalid.
// Throughput: one request per cycle while out_tready stays high; the state updates of
//   one request finish in the decision stage, so the next can follow directly behind it.
// Reset (rst_n low, synchronous): configuration returns to its defaults, the
//   ground counter and all history cells clear to zero, no request is held.
// Stall: when out_tready is low the result stays in the output register, one
//   more request waits in the square stage, and in_tready then drops.
`timescale 1ns / 1ps
`default_nettype none

module tilt_and_rate_safety_monitor #(
  parameter int HISTORY_DEPTH = tarsm_pkg::HISTORY_DEPTH
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // quat_x[15:0], quat_y[31:16], height_mm[47:32], rate_roll[63:48], rate_pitch[79:64]
  input  wire  [tarsm_pkg::IN_W-1:0]    in_tdata,
  input  wire                           in_tvalid,
  output logic                          in_tready,
  // tilt_cosine[15:0], stop_request[16], near_ground[17], ground_tilt_trip[18],
  // ground_rate_trip[19], flight_tilt_trip[20], zero[23:21]
  output logic [tarsm_pkg::OUT_W-1:0]   out_tdata,
  output logic                          out_tvalid,
  input  wire                           out_tready,
  input  wire                           cfg_we,
  input  wire  [tarsm_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire  [tarsm_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int TW = tarsm_pkg::TILT_W;
  localparam int CW = tarsm_pkg::CNT_W;

  // configuration registers
  logic                           enable_r;
  logic [tarsm_pkg::HGT_W-1:0]    ground_hgt_r;
  logic signed [TW-1:0]           ground_tilt_r;
  logic signed [TW-1:0]           flight_tilt_r;
  logic [tarsm_pkg::RATE_W-1:0]   rate_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= tarsm_pkg::ENABLE_RST;
      ground_hgt_r  <= tarsm_pkg::GROUND_HGT_RST;
      ground_tilt_r <= tarsm_pkg::GROUND_TILT_RST;
      flight_tilt_r <= tarsm_pkg::FLIGHT_TILT_RST;
      rate_limit_r  <= tarsm_pkg::RATE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (tarsm_pkg::cfg_idx_t'(cfg_addr))
        tarsm_pkg::CFG_ENABLE:      enable_r      <= cfg_wdata[0];
        tarsm_pkg::CFG_GROUND_HGT:  ground_hgt_r  <= cfg_wdata[tarsm_pkg::HGT_W-1:0];
        tarsm_pkg::CFG_GROUND_TILT: ground_tilt_r <= cfg_wdata;
        tarsm_pkg::CFG_FLIGHT_TILT: flight_tilt_r <= cfg_wdata;
        tarsm_pkg::CFG_RATE_LIMIT:  rate_limit_r  <= cfg_wdata[tarsm_pkg::RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake and stage control
  logic a_valid_r;
  logic a_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic adv;
  logic in_acc;

  assign adv       = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    a_valid_nxt   = in_acc ? 1'b1 : (adv ? 1'b0 : a_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // square stage
  tarsm_pkg::front_t front;

  tarsm_front u_front (
    .clk              (clk),
    .load             (in_acc),
    .in_data          (in_tdata),
    .ground_height_mm (ground_hgt_r),
    .rate_limit       (rate_limit_r),
    .front_r          (front)
  );

  // tilt cosine: 32767 - ((x*x + y*y + 8192) >> 14), only the low side can clamp
  logic [tarsm_pkg::SUM_W-1:0]                   sq_sum;
  logic [tarsm_pkg::SUM_W-tarsm_pkg::TILT_SHIFT-1:0] sq_q;
  logic signed [tarsm_pkg::SUM_W-tarsm_pkg::TILT_SHIFT:0] r_wide;
  logic signed [TW-1:0]                          r33;

  assign sq_sum = {1'b0, front.sq_x} + {1'b0, front.sq_y} + tarsm_pkg::TILT_ROUND;
  assign sq_q   = sq_sum[tarsm_pkg::SUM_W-1:tarsm_pkg::TILT_SHIFT];
  assign r_wide = $signed({3'b000, tarsm_pkg::TILT_ONE}) - $signed({1'b0, sq_q});
  assign r33    = (r_wide < -19'sd32768) ? 16'sh8000 : r_wide[TW-1:0];

  // near-ground counter
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          near_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (enable_r) begin
      if (front.height_low) begin
        if (cnt_r < tarsm_pkg::COUNT_MAX) begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end else if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 7'd1;
      end
    end
  end

  assign near_nxt = cnt_nxt > tarsm_pkg::NEAR_LEVEL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (adv) begin
      cnt_r <= cnt_nxt;
    end
  end

  // history cell rows
  logic                 g_shift;
  logic                 f_shift;
  logic signed [TW-1:0] g_val [HISTORY_DEPTH];
  logic signed [TW-1:0] f_val [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] g_below;
  logic [HISTORY_DEPTH-1:0] f_below;

  assign g_shift = adv && enable_r && near_nxt;
  assign f_shift = adv && enable_r;

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cells
    logic signed [TW-1:0] g_in;
    logic signed [TW-1:0] f_in;
    if (i == 0) begin : g_head
      assign g_in = r33;
      assign f_in = r33;
    end else begin : g_link
      assign g_in = g_val[i-1];
      assign f_in = f_val[i-1];
    end

    tarsm_hist_cell u_ground (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (g_shift),
      .d_in      (g_in),
      .limit     (ground_tilt_r),
      .val_r     (g_val[i]),
      .below_nxt (g_below[i])
    );

    tarsm_hist_cell u_flight (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (f_shift),
      .d_in      (f_in),
      .limit     (flight_tilt_r),
      .val_r     (f_val[i]),
      .below_nxt (f_below[i])
    );
  end

  // trip decisions and output register
  logic gtilt;
  logic grate;
  logic ftilt;
  logic [tarsm_pkg::OUT_W-1:0] out_nxt;
  logic [tarsm_pkg::OUT_W-1:0] out_data_r;

  assign gtilt = enable_r && near_nxt && (&g_below);
  assign grate = enable_r && near_nxt && front.rate_over;
  assign ftilt = enable_r && (&f_below);

  assign out_nxt = {3'b000, ftilt, grate, gtilt, near_nxt, (gtilt || grate || ftilt), r33};

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire
